// ----- src/mhpq_pkg.sv -----
`default_nettype none

package mhpq_pkg;

  localparam int unsigned HEAP_DEPTH = 64;
  localparam int unsigned PRIO_W     = 16;
  localparam int unsigned TAG_W      = 8;
  localparam int unsigned ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);
  // Wide enough to hold 2 * pos + 2 for any slot index.
  localparam int unsigned IDX_W      = ADDR_W + 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = ((PRIO_W + TAG_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((PRIO_W + TAG_W + CNT_W + 7) / 8) * 8;
  localparam int unsigned STEP_W     = 4;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Microprogram addresses.
  typedef enum logic [STEP_W-1:0] {
    S_IDLE      = 4'd0,
    S_INS_TEST  = 4'd1,
    S_INS_UP    = 4'd2,
    S_INS_PLACE = 4'd3,
    S_REM_ROOT  = 4'd4,
    S_REM_LAST  = 4'd5,
    S_REM_LOAD  = 4'd6,
    S_DN_TEST   = 4'd7,
    S_DN_LEFT   = 4'd8,
    S_DN_RIGHT  = 4'd9,
    S_DN_CMP    = 4'd10,
    S_DN_PLACE  = 4'd11,
    S_FINISH    = 4'd12
  } step_e;

  // Memory read address source.
  typedef enum logic [2:0] {
    RD_ROOT   = 3'd0,
    RD_PARENT = 3'd1,
    RD_LEFT   = 3'd2,
    RD_RIGHT  = 3'd3,
    RD_LAST   = 3'd4
  } rd_e;

  // Condition that gates the action and steers conditional jumps.
  typedef enum logic [2:0] {
    C_ALWAYS       = 3'd0,
    C_ACCEPT       = 3'd1,
    C_POS_ZERO     = 3'd2,
    C_UP_SWAP      = 3'd3,
    C_NO_LEFT      = 3'd4,
    C_RIGHT_BETTER = 3'd5,
    C_DOWN_SWAP    = 3'd6,
    C_OUT_FREE     = 3'd7
  } cond_e;

  typedef enum logic [3:0] {
    A_NONE       = 4'd0,
    A_ACCEPT     = 4'd1,
    A_MOVE_UP    = 4'd2,
    A_PLACE      = 4'd3,
    A_TAKE_ROOT  = 4'd4,
    A_LOAD_MOV   = 4'd5,
    A_CAND_LEFT  = 4'd6,
    A_CAND_RIGHT = 4'd7,
    A_MOVE_DOWN  = 4'd8,
    A_RESULT     = 4'd9
  } act_e;

  typedef enum logic [2:0] {
    J_NEXT      = 3'd0,
    J_GOTO      = 3'd1,
    J_IF        = 3'd2,
    J_DISPATCH  = 3'd3,
    J_FIRE_GOTO = 3'd4
  } jmp_e;

  typedef struct packed {
    rd_e   rd;
    cond_e cond;
    act_e  act;
    jmp_e  jmp;
    step_e target;
  } ctrl_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic is_remove;
    logic reject;
    logic pos_zero;
    logic up_swap;
    logic no_left;
    logic right_better;
    logic down_swap;
    logic out_free;
  } flags_t;

  // Sequencer commands to the datapath.
  typedef struct packed {
    rd_e  rd;
    act_e act;
    logic fire;
    logic idle;
  } uop_t;

endpackage

`default_nettype wire

// ----- src/mhpq_ram.sv -----
`default_nettype none

module mhpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- src/mhpq_seq.sv -----
`default_nettype none

module mhpq_seq
  import mhpq_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire flags_t flags_i,
  output uop_t        uop_o
);

  // Control store. Each word names a read address, a condition, the action
  // taken when the condition holds, and how the step counter moves.
  function automatic ctrl_t ucode(step_e s);
    ctrl_t w;
    w = '{rd: RD_ROOT, cond: C_ALWAYS, act: A_NONE, jmp: J_GOTO, target: S_IDLE};
    unique case (s)
      S_IDLE:      w = '{RD_ROOT,   C_ACCEPT,       A_ACCEPT,     J_DISPATCH,  S_IDLE};
      S_INS_TEST:  w = '{RD_PARENT, C_POS_ZERO,     A_NONE,       J_IF,        S_INS_PLACE};
      S_INS_UP:    w = '{RD_ROOT,   C_UP_SWAP,      A_MOVE_UP,    J_IF,        S_INS_TEST};
      S_INS_PLACE: w = '{RD_ROOT,   C_ALWAYS,       A_PLACE,      J_GOTO,      S_FINISH};
      S_REM_ROOT:  w = '{RD_ROOT,   C_ALWAYS,       A_NONE,       J_NEXT,      S_IDLE};
      S_REM_LAST:  w = '{RD_LAST,   C_ALWAYS,       A_TAKE_ROOT,  J_NEXT,      S_IDLE};
      S_REM_LOAD:  w = '{RD_ROOT,   C_ALWAYS,       A_LOAD_MOV,   J_NEXT,      S_IDLE};
      S_DN_TEST:   w = '{RD_LEFT,   C_NO_LEFT,      A_NONE,       J_IF,        S_DN_PLACE};
      S_DN_LEFT:   w = '{RD_RIGHT,  C_ALWAYS,       A_CAND_LEFT,  J_NEXT,      S_IDLE};
      S_DN_RIGHT:  w = '{RD_ROOT,   C_RIGHT_BETTER, A_CAND_RIGHT, J_NEXT,      S_IDLE};
      S_DN_CMP:    w = '{RD_ROOT,   C_DOWN_SWAP,    A_MOVE_DOWN,  J_IF,        S_DN_TEST};
      S_DN_PLACE:  w = '{RD_ROOT,   C_ALWAYS,       A_PLACE,      J_GOTO,      S_FINISH};
      S_FINISH:    w = '{RD_ROOT,   C_OUT_FREE,     A_RESULT,     J_FIRE_GOTO, S_IDLE};
      default:     w = '{RD_ROOT,   C_ALWAYS,       A_NONE,       J_GOTO,      S_IDLE};
    endcase
    return w;
  endfunction

  step_e step_q, step_d;
  ctrl_t word;
  logic  fire;
  step_e step_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    word     = ucode(step_q);
    step_inc = step_e'(step_q + STEP_W'(1));

    unique case (word.cond)
      C_ALWAYS:       fire = 1'b1;
      C_ACCEPT:       fire = flags_i.in_valid;
      C_POS_ZERO:     fire = flags_i.pos_zero;
      C_UP_SWAP:      fire = flags_i.up_swap;
      C_NO_LEFT:      fire = flags_i.no_left;
      C_RIGHT_BETTER: fire = flags_i.right_better;
      C_DOWN_SWAP:    fire = flags_i.down_swap;
      C_OUT_FREE:     fire = flags_i.out_free;
    endcase

    unique case (word.jmp)
      J_NEXT:      step_d = step_inc;
      J_GOTO:      step_d = word.target;
      J_IF:        step_d = fire ? word.target : step_inc;
      J_FIRE_GOTO: step_d = fire ? word.target : step_q;
      J_DISPATCH: begin
        priority if (!fire) begin
          step_d = step_q;
        end else if (flags_i.reject) begin
          step_d = S_FINISH;
        end else if (flags_i.is_remove) begin
          step_d = S_REM_ROOT;
        end else begin
          step_d = S_INS_TEST;
        end
      end
      default:     step_d = S_IDLE;
    endcase

    uop_o.rd   = word.rd;
    uop_o.act  = word.act;
    uop_o.fire = fire;
    uop_o.idle = (step_q == S_IDLE);
  end

endmodule

`default_nettype wire

// ----- src/mhpq_dp.sv -----
`default_nettype none

module mhpq_dp
  import mhpq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire uop_t              uop_i,
  input  wire logic              in_valid_i,
  input  wire logic              in_op_i,
  input  wire logic [PRIO_W-1:0] in_prio_i,
  input  wire logic [TAG_W-1:0]  in_tag_i,
  input  wire logic              out_ready_i,
  output flags_t                 flags_o,
  output logic                   out_valid_o,
  output logic [STATUS_W-1:0]    out_status_o,
  output entry_t                 out_entry_o,
  output logic [CNT_W-1:0]       out_count_o
);

  logic [CNT_W-1:0]  cnt_q;
  logic              res_valid_q;
  logic [ADDR_W-1:0] pos_q;
  logic [ADDR_W-1:0] cidx_q;
  entry_t            mov_q;
  entry_t            cand_q;
  entry_t            taken_q;
  status_e           status_q;
  status_e           res_status_q;
  entry_t            res_entry_q;
  logic [CNT_W-1:0]  res_cnt_q;

  logic [ADDR_W-1:0] parent_idx;
  logic [IDX_W-1:0]  left_idx;
  logic [IDX_W-1:0]  right_idx;
  logic [IDX_W-1:0]  cnt_ext;
  logic              right_ok;
  logic              is_full;
  logic              is_empty;
  logic              go;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  entry_t            wdata;
  logic [ADDR_W-1:0] raddr;
  logic [ENTRY_W-1:0] rdata_raw;
  entry_t            rdata;

  assign rdata = entry_t'(rdata_raw);
  assign go    = uop_i.fire;

  always_comb begin
    parent_idx = (pos_q - ADDR_W'(1)) >> 1;
    left_idx   = IDX_W'({pos_q, 1'b1});
    right_idx  = (IDX_W'(pos_q) + IDX_W'(1)) << 1;
    cnt_ext    = IDX_W'(cnt_q);
    right_ok   = (right_idx < cnt_ext);
    is_full    = (cnt_q == CNT_W'(HEAP_DEPTH));
    is_empty   = (cnt_q == '0);

    flags_o.in_valid     = in_valid_i;
    flags_o.is_remove    = (in_op_i == OP_REMOVE);
    flags_o.reject       = (in_op_i == OP_REMOVE) ? is_empty : is_full;
    flags_o.pos_zero     = (pos_q == '0);
    flags_o.up_swap      = (rdata.prio > mov_q.prio);
    flags_o.no_left      = !(left_idx < cnt_ext);
    flags_o.right_better = right_ok && (rdata.prio < cand_q.prio);
    flags_o.down_swap    = (cand_q.prio < mov_q.prio);
    flags_o.out_free     = !res_valid_q || out_ready_i;

    unique case (uop_i.rd)
      RD_ROOT:   raddr = '0;
      RD_PARENT: raddr = parent_idx;
      RD_LEFT:   raddr = left_idx[ADDR_W-1:0];
      RD_RIGHT:  raddr = right_idx[ADDR_W-1:0];
      RD_LAST:   raddr = cnt_q[ADDR_W-1:0];
      default:   raddr = '0;
    endcase

    // All writes land on the hole at pos_q.
    waddr = pos_q;
    we    = 1'b0;
    wdata = mov_q;
    if (go) begin
      unique case (uop_i.act)
        A_MOVE_UP: begin
          we    = 1'b1;
          wdata = rdata;
        end
        A_MOVE_DOWN: begin
          we    = 1'b1;
          wdata = cand_q;
        end
        A_PLACE: begin
          we    = 1'b1;
          wdata = mov_q;
        end
        default: begin
          we    = 1'b0;
          wdata = mov_q;
        end
      endcase
    end
  end

  mhpq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(HEAP_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_valid_q && out_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (go && uop_i.act == A_RESULT) begin
        res_valid_q <= 1'b1;
      end
      if (go && uop_i.act == A_ACCEPT) begin
        if (in_op_i == OP_REMOVE) begin
          if (!is_empty) begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end else if (!is_full) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      unique case (uop_i.act)
        A_ACCEPT: begin
          mov_q   <= '{prio: in_prio_i, tag: in_tag_i};
          taken_q <= '0;
          if (in_op_i == OP_REMOVE) begin
            status_q <= is_empty ? ST_EMPTY : ST_OK;
            pos_q    <= '0;
          end else begin
            status_q <= is_full ? ST_FULL : ST_OK;
            pos_q    <= cnt_q[ADDR_W-1:0];
          end
        end
        A_MOVE_UP:    pos_q   <= parent_idx;
        A_MOVE_DOWN:  pos_q   <= cidx_q;
        A_TAKE_ROOT:  taken_q <= rdata;
        A_LOAD_MOV:   mov_q   <= rdata;
        A_CAND_LEFT: begin
          cand_q <= rdata;
          cidx_q <= left_idx[ADDR_W-1:0];
        end
        A_CAND_RIGHT: begin
          cand_q <= rdata;
          cidx_q <= right_idx[ADDR_W-1:0];
        end
        A_RESULT: begin
          res_status_q <= status_q;
          res_entry_q  <= taken_q;
          res_cnt_q    <= cnt_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o  = res_valid_q;
  assign out_status_o = res_status_q;
  assign out_entry_o  = res_entry_q;
  assign out_count_o  = res_cnt_q;

endmodule

`default_nettype wire

// ----- src/min_heap_priority_queue.sv -----
`default_nettype none

// Binary min-heap priority queue of up to 64 entries, each a 16-bit priority
// and an 8-bit process tag; a lower priority is served first. Each input item
// is an insert (tuser 0) or a remove of the minimum (tuser 1) and yields exactly
// one result item carrying a status, the removed entry (zero for inserts and
// failures) and the entry count after the operation. An insert into a full
// heap is dropped with status 1; a remove from an empty heap reports status 2.
// The heap lives in a single-port-read, single-port-write RAM with registered
// read data, and a small microcoded sequencer walks the sift loops one memory
// access per cycle. An insert climbs and a remove descends at most 6 levels
// for 64 entries; each level costs one RAM read per visited slot plus a
// compare-and-move step. An item is held at its finish step while the
// previous result still waits in the output register. One item is in work at
// a time; the finished result sits in an output register, so a new item is
// taken while the previous result still waits to be read. The heap memory
// needs no clearing after reset.
module min_heap_priority_queue
  import mhpq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: new_priority [15:0], new_tag [23:16].
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: op (0 insert, 1 remove).
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: out_priority [15:0], out_tag [23:16], entry_count [30:24], zero fill.
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // tuser: status (0 ok, 1 insert dropped, 2 remove on empty heap).
  output logic [STATUS_W-1:0]        m_axis_tuser
);

  flags_t           flags;
  uop_t             uop;
  entry_t           res_entry;
  logic [CNT_W-1:0] res_count;

  // The sequencer owns all control; the datapath holds the heap and the
  // registers that the microprogram steers.
  mhpq_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flags_i(flags),
    .uop_o  (uop)
  );

  mhpq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uop_i       (uop),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_prio_i   (s_axis_tdata[PRIO_W-1:0]),
    .in_tag_i    (s_axis_tdata[PRIO_W+TAG_W-1:PRIO_W]),
    .out_ready_i (m_axis_tready),
    .flags_o     (flags),
    .out_valid_o (m_axis_tvalid),
    .out_status_o(m_axis_tuser),
    .out_entry_o (res_entry),
    .out_count_o (res_count)
  );

  // Items are taken only while the sequencer sits at its idle step.
  assign s_axis_tready = uop.idle;

  assign m_axis_tdata = OUT_DATA_W'({res_count, res_entry.tag, res_entry.prio});

endmodule

`default_nettype wire

// ----- verif/tb_min_heap_priority_queue.sv -----
`default_nettype none

// Self-checking bench for the min-heap priority queue. A short table of directed
// items (empty corners, extreme values, ties) runs first. Random
// traffic follows in fill, mixed and drain runs, so the heap goes through full
// and empty again and again. A local copy of the heap predicts every result,
// and each result item is compared with the oldest expectation.
module tb_min_heap_priority_queue;
  import mhpq_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    status_e            status;
    logic [PRIO_W-1:0]  prio;
    logic [TAG_W-1:0]   tag;
    logic [CNT_W-1:0]   count;
  } heap_result_t;

  typedef struct {
    op_e               op;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
    bit                typed;
    heap_result_t      want;
  } stim_row_t;

  typedef enum int {TR_FILL, TR_MIX, TR_DRAIN} traffic_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  // Local copy of the heap used for prediction.
  logic [PRIO_W-1:0] heap_prio [HEAP_DEPTH];
  logic [TAG_W-1:0]  heap_tag  [HEAP_DEPTH];
  int                heap_fill = 0;
  int                peak_fill = 0;

  heap_result_t pending_results [$];
  stim_row_t    directed_rows [$];

  int items_offered = 0;
  int results_checked = 0;
  int fail_count = 0;
  int full_drops = 0;
  int empty_removes = 0;
  int cycle_count = 0;
  int snd_idle_pct = 26;
  int rcv_idle_pct = 79;

  min_heap_priority_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic void heap_swap(input int a, input int b);
    logic [PRIO_W-1:0] tp;
    logic [TAG_W-1:0]  tt;
    tp = heap_prio[a];
    tt = heap_tag[a];
    heap_prio[a] = heap_prio[b];
    heap_tag[a]  = heap_tag[b];
    heap_prio[b] = tp;
    heap_tag[b]  = tt;
  endfunction

  // Applies one operation to the local heap and returns the result it yields.
  function automatic heap_result_t predict_heap_op(input op_e op,
                                                   input logic [PRIO_W-1:0] prio,
                                                   input logic [TAG_W-1:0] tag);
    heap_result_t r;
    int pos;
    int lc;
    int rc;
    int best;
    bit moving;
    r.status = ST_OK;
    r.prio   = '0;
    r.tag    = '0;
    if (op == OP_INSERT) begin
      if (heap_fill >= HEAP_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        heap_prio[heap_fill] = prio;
        heap_tag[heap_fill]  = tag;
        pos = heap_fill;
        heap_fill++;
        // Climb while the parent is strictly greater.
        while (pos != 0 && heap_prio[(pos - 1) / 2] > heap_prio[pos]) begin
          heap_swap(pos, (pos - 1) / 2);
          pos = (pos - 1) / 2;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.prio = heap_prio[0];
        r.tag  = heap_tag[0];
        heap_fill--;
        heap_prio[0] = heap_prio[heap_fill];
        heap_tag[0]  = heap_tag[heap_fill];
        pos = 0;
        moving = 1'b1;
        // Sink toward the smaller child; the left child wins a tie.
        while (moving) begin
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          best = pos;
          if (lc < heap_fill && heap_prio[lc] < heap_prio[best]) best = lc;
          if (rc < heap_fill && heap_prio[rc] < heap_prio[best]) best = rc;
          if (best == pos) begin
            moving = 1'b0;
          end else begin
            heap_swap(pos, best);
            pos = best;
          end
        end
      end
    end
    if (heap_fill > peak_fill) peak_fill = heap_fill;
    r.count = heap_fill[CNT_W-1:0];
    return r;
  endfunction

  function automatic logic [PRIO_W-1:0] pick_priority();
    logic [PRIO_W-1:0] p;
    case ($urandom_range(0, 9))
      0: p = '0;
      1: p = '1;
      2, 3, 4: p = PRIO_W'($urandom_range(0, 7));
      default: p = PRIO_W'($urandom);
    endcase
    return p;
  endfunction

  task automatic add_row(input op_e op, input logic [PRIO_W-1:0] prio,
                         input logic [TAG_W-1:0] tag, input bit typed,
                         input status_e st, input logic [PRIO_W-1:0] oprio,
                         input logic [TAG_W-1:0] otag, input int cnt);
    stim_row_t row;
    row.op          = op;
    row.prio        = prio;
    row.tag         = tag;
    row.typed       = typed;
    row.want.status = st;
    row.want.prio   = oprio;
    row.want.tag    = otag;
    row.want.count  = CNT_W'(cnt);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Offers one item, waits for the handshake, then records what it must yield.
  // A typed expectation replaces the predicted one, but the local heap is
  // always updated.
  task automatic offer_item(input op_e op, input logic [PRIO_W-1:0] prio,
                            input logic [TAG_W-1:0] tag, input bit typed,
                            input heap_result_t want, output heap_result_t got);
    heap_result_t model_res;
    if (items_offered < 275) begin
      snd_idle_pct = 26;
      rcv_idle_pct = 79;
    end else if (items_offered < 525) begin
      snd_idle_pct = 79;
      rcv_idle_pct = 26;
    end else begin
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_DATA_W'($urandom);
      s_axis_tuser  <= 1'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tag, prio};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    model_res = predict_heap_op(op, prio, tag);
    pending_results.insert(pending_results.size(), typed ? want : model_res);
    if (model_res.status == ST_FULL) full_drops++;
    if (model_res.status == ST_EMPTY) empty_removes++;
    items_offered++;
    got = model_res;
  endtask

  // Result side: random back-pressure and the comparison with the oldest
  // expectation. Outputs are read right after the edge, so they hold the
  // values that the handshake saw.
  always @(posedge clk_i) begin : result_check
    heap_result_t want;
    logic [PRIO_W-1:0] act_prio;
    logic [TAG_W-1:0]  act_tag;
    logic [CNT_W-1:0]  act_count;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act_prio  = m_axis_tdata[PRIO_W-1:0];
      act_tag   = m_axis_tdata[PRIO_W +: TAG_W];
      act_count = m_axis_tdata[PRIO_W + TAG_W +: CNT_W];
      if (pending_results.size() == 0) begin
        $error("result item with no expectation waiting: status %0d count %0d",
               m_axis_tuser, act_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          fail_count++;
        end
        if (act_prio !== want.prio) begin
          $error("out_priority: expected %0h, got %0h", want.prio, act_prio);
          fail_count++;
        end
        if (act_tag !== want.tag) begin
          $error("out_tag: expected %0h, got %0h", want.tag, act_tag);
          fail_count++;
        end
        if (act_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, act_count);
          fail_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    heap_result_t got;
    heap_result_t none;
    traffic_e traffic;
    int run_step;
    int run_items;
    int run_len;
    int run_hits;
    int insert_pct;
    int random_items;
    op_e op;

    none.status = ST_OK;
    none.prio   = '0;
    none.tag    = '0;
    none.count  = '0;

    // Corners with obvious answers: empty heap, both extreme entries.
    add_row(OP_REMOVE, 16'h0000, 8'h00, 1'b1, ST_EMPTY, 16'h0000, 8'h00, 0);
    add_row(OP_INSERT, 16'hFFFF, 8'hFF, 1'b1, ST_OK,    16'h0000, 8'h00, 1);
    add_row(OP_INSERT, 16'h0000, 8'h00, 1'b1, ST_OK,    16'h0000, 8'h00, 2);
    add_row(OP_REMOVE, 16'h0000, 8'h00, 1'b1, ST_OK,    16'h0000, 8'h00, 1);
    add_row(OP_REMOVE, 16'h0000, 8'h00, 1'b1, ST_OK,    16'hFFFF, 8'hFF, 0);
    add_row(OP_REMOVE, 16'h1234, 8'h56, 1'b1, ST_EMPTY, 16'h0000, 8'h00, 0);
    // Equal priorities exercise the tie rules on the way up and down.
    add_row(OP_INSERT, 16'd5, 8'h11, 1'b0, ST_OK, '0, '0, 0);
    add_row(OP_INSERT, 16'd5, 8'h22, 1'b0, ST_OK, '0, '0, 0);
    add_row(OP_INSERT, 16'd5, 8'h33, 1'b0, ST_OK, '0, '0, 0);
    add_row(OP_INSERT, 16'd5, 8'h44, 1'b0, ST_OK, '0, '0, 0);
    add_row(OP_INSERT, 16'd3, 8'h55, 1'b0, ST_OK, '0, '0, 0);
    add_row(OP_INSERT, 16'd5, 8'h66, 1'b0, ST_OK, '0, '0, 0);
    for (int i = 0; i < 6; i++) add_row(OP_REMOVE, '0, '0, 1'b0, ST_OK, '0, '0, 0);
    // Alternating bit patterns and the sign-bit boundary in both fields.
    add_row(OP_INSERT, 16'hAAAA, 8'h55, 1'b0, ST_OK, '0, '0, 0);
    add_row(OP_INSERT, 16'h5555, 8'hAA, 1'b0, ST_OK, '0, '0, 0);
    add_row(OP_INSERT, 16'h8000, 8'h80, 1'b0, ST_OK, '0, '0, 0);
    add_row(OP_INSERT, 16'h7FFF, 8'h7F, 1'b0, ST_OK, '0, '0, 0);
    for (int i = 0; i < 3; i++) add_row(OP_REMOVE, '0, '0, 1'b0, ST_OK, '0, '0, 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].op, directed_rows[i].prio, directed_rows[i].tag,
                 directed_rows[i].typed, directed_rows[i].want, got);
    end

    // Random runs cycle through fill, mixed, drain, mixed. A fill run ends
    // after three dropped inserts and a drain run after three removes on an
    // empty heap, so both corners recur.
    random_items = 0;
    run_step = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (run_step % 4)
        0: traffic = TR_FILL;
        2: traffic = TR_DRAIN;
        default: traffic = TR_MIX;
      endcase
      insert_pct = (traffic == TR_FILL) ? 92 : (traffic == TR_DRAIN) ? 8 : 50;
      run_len = (traffic == TR_MIX) ? $urandom_range(60, 120) : 150;
      run_items = 0;
      run_hits = 0;
      while (run_items < run_len && run_hits < 3 && random_items < RANDOM_ITEMS) begin
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        offer_item(op, pick_priority(), TAG_W'($urandom), 1'b0, none, got);
        if ((traffic == TR_FILL && got.status == ST_FULL) ||
            (traffic == TR_DRAIN && got.status == ST_EMPTY)) begin
          run_hits++;
        end
        run_items++;
        random_items++;
      end
      run_step++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d items (%0d from the directed table); %0d results compared.",
             items_offered, directed_rows.size(), results_checked);
    $display("Inserts dropped on a full heap: %0d, removes on an empty heap: %0d, peak fill %0d.",
             full_drops, empty_removes, peak_fill);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
src/mhpq_pkg.sv
src/mhpq_ram.sv
src/mhpq_seq.sv
src/mhpq_dp.sv
src/min_heap_priority_queue.sv
verif/tb_min_heap_priority_queue.sv
